// ----- sv/zcwd_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, register indexes and types of the zero-crossing window detector.
package zcwd_pkg;

    localparam int MAX_WIDTH     = 1024;
    localparam int COL_BITS      = $clog2(MAX_WIDTH);
    localparam int MAX_WINDOW    = 7;
    localparam int HIST_ROWS     = MAX_WINDOW - 1;
    localparam int HIST_BITS     = 2 * HIST_ROWS;
    localparam int SAMPLE_BITS   = 16;

    localparam int THR_BITS      = 15;
    localparam int WS_BITS       = 3;
    localparam int FW_BITS       = 11;
    localparam int FH_BITS       = 13;
    localparam int ROW_BITS      = 13;
    localparam int HALF_BITS     = 2;
    localparam int LAG_BITS      = 12;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 15;

    localparam logic [FW_BITS-1:0] WIDTH_LIMIT  = FW_BITS'(MAX_WIDTH);
    localparam logic [FH_BITS-1:0] HEIGHT_LIMIT = FH_BITS'(4096);

    localparam logic [THR_BITS-1:0] THR_RESET = '0;
    localparam logic [WS_BITS-1:0]  WS_RESET  = WS_BITS'(3);
    localparam logic [FW_BITS-1:0]  FW_RESET  = FW_BITS'(1024);
    localparam logic [FH_BITS-1:0]  FH_RESET  = FH_BITS'(1024);

    localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_SIZE  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 2'd3;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    localparam logic [1:0] FLAG_NONE = 2'b00;
    localparam logic [1:0] FLAG_BOTH = 2'b11;

    typedef struct packed {
        logic [COL_BITS-1:0]   col;
        logic [1:0]            flag;
        logic [MAX_WINDOW-1:0] row_en;
        logic [MAX_WINDOW-1:0] col_en;
        logic                  emit;
        logic                  last;
    } t_item;

    typedef struct packed {
        logic busy;
        logic flush;
    } t_ctrl_stat;

endpackage

// ----- sv/zero_crossing_window_detect_top.sv -----
`timescale 1ns / 1ps
// Path: a result word passes the stage-1 register and then the output register once the
// input word that completes its window is accepted; an output stall can hold it between.
// Throughput: one word per cycle unless an output stall or history advance holds it; the
// column history memory is read and rewritten per word. A frame with fewer samples than
// its window lag stalls input after its last sample while zero rows advance the history.
// Reset: synchronous, active low; clears control and loads register defaults, not memory.
module zero_crossing_window_detect_top import zcwd_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]       i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0]      i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_in_cmd,
    input  logic signed [SAMPLE_BITS-1:0] i_in_sample,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_out_edge_res,
    output logic                          o_out_last
);

    logic       w_s1_free;
    logic       w_step;
    t_item      w_item;
    t_ctrl_stat w_stat;

    zcwd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_cmd    (i_in_cmd),
        .i_in_sample (i_in_sample),
        .o_in_stall  (o_in_stall),
        .i_s1_free   (w_s1_free),
        .o_step      (w_step),
        .o_item      (w_item),
        .o_stat      (w_stat)
    );

    zcwd_win u_win (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_step),
        .i_item         (w_item),
        .o_s1_free      (w_s1_free),
        .o_out_valid    (o_out_valid),
        .o_out_edge_res (o_out_edge_res),
        .o_out_last     (o_out_last),
        .i_out_stall    (i_out_stall)
    );

    a_emit_has_column: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step && w_item.emit |-> w_item.col_en != '0)
        else $error("emitting word has an empty column window");

    a_flush_no_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step && w_stat.flush |-> !w_item.emit)
        else $error("history advance word produced a result");

    a_flush_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.flush |-> w_stat.busy)
        else $error("history advance outside a frame");

endmodule

// ----- sv/zcwd_ctrl.sv -----
`timescale 1ns / 1ps
// Configuration registers, frame counters and window masks of the detector front end.
module zcwd_ctrl import zcwd_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]       i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0]      i_cfg_data,
    input  logic                          i_in_valid,
    input  logic                          i_in_cmd,
    input  logic signed [SAMPLE_BITS-1:0] i_in_sample,
    output logic                          o_in_stall,
    input  logic                          i_s1_free,
    output logic                          o_step,
    output t_item                         o_item,
    output t_ctrl_stat                    o_stat
);

    logic [THR_BITS-1:0]  r_thr;
    logic [WS_BITS-1:0]   r_ws;
    logic [FW_BITS-1:0]   r_fw;
    logic [FH_BITS-1:0]   r_fh;

    logic                 r_busy;
    logic                 r_flush;
    logic [FW_BITS-1:0]   r_act_w;
    logic [FH_BITS-1:0]   r_act_h;
    logic [HALF_BITS-1:0] r_half;
    logic [COL_BITS-1:0]  r_col;
    logic [ROW_BITS-1:0]  r_row;
    logic [COL_BITS-1:0]  r_ox;
    logic [ROW_BITS-1:0]  r_oy;
    logic [LAG_BITS-1:0]  r_lag;

    logic                 go;
    logic                 drain;
    logic                 start;
    logic                 in_phase;
    logic                 act;
    logic                 emit;
    logic                 col_last;
    logic                 row_last;
    logic                 out_col_last;
    logic                 out_last;
    logic [FW_BITS-1:0]   w_new;
    logic [FH_BITS-1:0]   h_new;
    logic [HALF_BITS-1:0] half_new;
    logic [LAG_BITS-1:0]  lag_new;
    logic [FW_BITS-1:0]   eff_w;
    logic [FH_BITS-1:0]   eff_h;
    logic [HALF_BITS-1:0] eff_half;
    logic [LAG_BITS-1:0]  eff_lag;
    logic [WS_BITS-1:0]   span;
    logic [COL_BITS+1:0]  oxh;
    logic [COL_BITS+1:0]  col_bound;
    logic signed [SAMPLE_BITS:0] s_ext;
    logic signed [SAMPLE_BITS:0] t_ext;
    logic [1:0]           flag;
    logic [MAX_WINDOW-1:0] row_en;
    logic [MAX_WINDOW-1:0] col_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
            r_ws  <= WS_RESET;
            r_fw  <= FW_RESET;
            r_fh  <= FH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_THRESHOLD:    r_thr <= i_cfg_data[THR_BITS-1:0];
                REG_WINDOW_SIZE:  r_ws  <= i_cfg_data[WS_BITS-1:0];
                REG_FRAME_WIDTH:  r_fw  <= i_cfg_data[FW_BITS-1:0];
                REG_FRAME_HEIGHT: r_fh  <= i_cfg_data[FH_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_new = (r_fw == '0) ? FW_BITS'(1) : ((r_fw > WIDTH_LIMIT) ? WIDTH_LIMIT : r_fw);
        h_new = (r_fh == '0) ? FH_BITS'(1) : ((r_fh > HEIGHT_LIMIT) ? HEIGHT_LIMIT : r_fh);
        half_new = r_ws[WS_BITS-1:1];
        lag_new = LAG_BITS'(w_new) * LAG_BITS'(half_new) + LAG_BITS'(half_new);
    end

    assign go    = i_s1_free && (r_flush || i_in_valid);
    assign drain = r_flush || (i_in_cmd == CMD_DRAIN);
    assign start = !drain && !r_busy;

    assign eff_w    = start ? w_new    : r_act_w;
    assign eff_h    = start ? h_new    : r_act_h;
    assign eff_half = start ? half_new : r_half;
    assign eff_lag  = start ? lag_new  : r_lag;

    assign in_phase = r_row < ROW_BITS'(eff_h);
    assign act      = (r_busy || start) && !(in_phase && drain);
    assign emit     = act && (eff_lag == '0);

    assign col_last     = r_col == COL_BITS'(eff_w - FW_BITS'(1));
    assign row_last     = r_row == ROW_BITS'(eff_h - FH_BITS'(1));
    assign out_col_last = r_ox == COL_BITS'(eff_w - FW_BITS'(1));
    assign out_last     = out_col_last && (r_oy == ROW_BITS'(eff_h - FH_BITS'(1)));

    assign s_ext = (SAMPLE_BITS+1)'(i_in_sample);
    assign t_ext = $signed({{(SAMPLE_BITS+1-THR_BITS){1'b0}}, r_thr});

    always_comb begin
        flag = FLAG_NONE;
        if (in_phase && !drain) begin
            flag[0] = s_ext > t_ext;
            flag[1] = s_ext < -t_ext;
        end
    end

    assign span      = {eff_half, 1'b0};
    assign oxh       = (COL_BITS+2)'(r_ox) + (COL_BITS+2)'(eff_half);
    assign col_bound = (COL_BITS+2)'(eff_w) - (COL_BITS+2)'(1);

    always_comb begin
        for (int j = 0; j < MAX_WINDOW; j++) begin
            row_en[j] = (WS_BITS'(j) <= span) && (ROW_BITS'(j) <= r_row);
            col_en[j] = (WS_BITS'(j) <= span) && (oxh >= (COL_BITS+2)'(j))
                        && (oxh <= col_bound + (COL_BITS+2)'(j));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_flush <= 1'b0;
            r_act_w <= FW_BITS'(1);
            r_act_h <= FH_BITS'(1);
            r_half  <= '0;
            r_col   <= '0;
            r_row   <= '0;
            r_ox    <= '0;
            r_oy    <= '0;
            r_lag   <= '0;
        end else if (go && act) begin
            if (start) begin
                r_act_w <= w_new;
                r_act_h <= h_new;
                r_half  <= half_new;
            end
            if (emit && out_last) begin
                r_busy  <= 1'b0;
                r_flush <= 1'b0;
                r_col   <= '0;
                r_row   <= '0;
                r_ox    <= '0;
                r_oy    <= '0;
                r_lag   <= '0;
            end else begin
                r_busy <= 1'b1;
                if (col_last) begin
                    r_col <= '0;
                    r_row <= r_row + ROW_BITS'(1);
                end else begin
                    r_col <= r_col + COL_BITS'(1);
                end
                r_lag <= (eff_lag == '0) ? '0 : eff_lag - LAG_BITS'(1);
                if (emit) begin
                    if (out_col_last) begin
                        r_ox <= '0;
                        r_oy <= r_oy + ROW_BITS'(1);
                    end else begin
                        r_ox <= r_ox + COL_BITS'(1);
                    end
                end
                if (r_flush) begin
                    r_flush <= eff_lag != LAG_BITS'(1);
                end else begin
                    r_flush <= in_phase && !drain && col_last && row_last
                               && (eff_lag >= LAG_BITS'(2));
                end
            end
        end
    end

    assign o_in_stall    = r_flush || !i_s1_free;
    assign o_step        = go && act;
    assign o_item.col    = r_col;
    assign o_item.flag   = flag;
    assign o_item.row_en = row_en;
    assign o_item.col_en = col_en;
    assign o_item.emit   = emit;
    assign o_item.last   = out_last;
    assign o_stat.busy   = r_busy;
    assign o_stat.flush  = r_flush;

endmodule

// ----- sv/zcwd_win.sv -----
`timescale 1ns / 1ps
// Column flag history memory, window OR stage and output register of the detector.
module zcwd_win import zcwd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_step,
    input  t_item i_item,
    output logic  o_s1_free,
    output logic  o_out_valid,
    output logic  o_out_edge_res,
    output logic  o_out_last,
    input  logic  i_out_stall
);

    logic [HIST_BITS-1:0] r_mem [MAX_WIDTH];
    logic [HIST_BITS-1:0] r_rd;
    logic [HIST_BITS-1:0] r_fwd_data;
    logic                 r_fwd;
    t_item                r_s1;
    logic                 r_s1_valid;
    logic [1:0]           r_cw [HIST_ROWS];
    logic                 r_out_valid;
    logic                 r_out_edge;
    logic                 r_out_last;

    logic                 s1_adv;
    logic                 s1_free;
    logic                 wr;
    logic [HIST_BITS-1:0] hist;
    logic [HIST_BITS-1:0] n_hist;
    logic [1:0]           vcol;
    logic [1:0]           acc;

    assign s1_adv  = !r_out_valid || !i_out_stall;
    assign s1_free = !r_s1_valid || s1_adv;
    assign wr      = r_s1_valid && s1_adv;

    assign hist   = r_fwd ? r_fwd_data : r_rd;
    assign n_hist = {hist[HIST_BITS-3:0], r_s1.flag};

    always_comb begin
        vcol = r_s1.flag;
        acc  = FLAG_NONE;
        for (int j = 1; j < MAX_WINDOW; j++) begin
            if (r_s1.row_en[j]) begin
                vcol = vcol | hist[2*(j-1) +: 2];
            end
        end
        if (r_s1.col_en[0]) begin
            acc = vcol;
        end
        for (int j = 1; j < MAX_WINDOW; j++) begin
            if (r_s1.col_en[j]) begin
                acc = acc | r_cw[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_s1.col] <= n_hist;
        end
        if (i_step) begin
            r_rd <= r_mem[i_item.col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_s1       <= i_item;
            r_fwd      <= wr && (r_s1.col == i_item.col);
            r_fwd_data <= n_hist;
        end
        if (wr) begin
            r_cw[0]    <= vcol;
            for (int i = 1; i < HIST_ROWS; i++) begin
                r_cw[i] <= r_cw[i-1];
            end
            r_out_edge <= acc == FLAG_BOTH;
            r_out_last <= r_s1.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= i_step;
            end
            if (s1_adv) begin
                r_out_valid <= r_s1_valid && r_s1.emit;
            end
        end
    end

    assign o_s1_free      = s1_free;
    assign o_out_valid    = r_out_valid;
    assign o_out_edge_res = r_out_edge;
    assign o_out_last     = r_out_last;

endmodule

// ----- test/tb_zero_crossing_window_detect_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of zero_crossing_window_detect_top with a window edge scoreboard.
module tb_zero_crossing_window_detect_top;
    import zcwd_pkg::*;

    localparam int RING_ROWS   = 2 * MAX_WINDOW + 1;
    localparam int QUIET_LIMIT = 20000;
    localparam int RANDOM_WORDS = 850;

    typedef struct packed {
        logic edge_res;
        logic last;
    } t_edge_word;

    class crossing_scoreboard;
        logic [THR_BITS-1:0] thr_reg;
        logic [WS_BITS-1:0]  win_reg;
        logic [FW_BITS-1:0]  fw_reg;
        logic [FH_BITS-1:0]  fh_reg;
        logic [1:0]          flag_ring [RING_ROWS][MAX_WIDTH];
        bit                  busy;
        int                  cols, rows, half;
        int                  col_at, row_at, words_in, results_out;
        int                  errors;
        t_edge_word          pending_edges [$];

        function new();
            thr_reg = THR_RESET;
            win_reg = WS_RESET;
            fw_reg  = FW_RESET;
            fh_reg  = FH_RESET;
            foreach (flag_ring[r, c]) flag_ring[r][c] = FLAG_NONE;
            busy = 0;
            cols = 1;
            rows = 1;
            half = 0;
            col_at = 0;
            row_at = 0;
            words_in = 0;
            results_out = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                REG_THRESHOLD:    thr_reg = data[THR_BITS-1:0];
                REG_WINDOW_SIZE:  win_reg = data[WS_BITS-1:0];
                REG_FRAME_WIDTH:  fw_reg  = data[FW_BITS-1:0];
                REG_FRAME_HEIGHT: fh_reg  = data[FH_BITS-1:0];
                default: ;
            endcase
        endfunction

        function int frame_words();
            return cols * rows;
        endfunction

        function void predict_window_edge();
            int ox, oy, r, c, dy, dx;
            logic [1:0] acc;
            t_edge_word w;
            ox = results_out % cols;
            oy = results_out / cols;
            acc = FLAG_NONE;
            for (dy = -half; dy <= half; dy++) begin
                r = oy + dy;
                if (r < 0 || r >= rows) continue;
                for (dx = -half; dx <= half; dx++) begin
                    c = ox + dx;
                    if (c < 0 || c >= cols) continue;
                    acc |= flag_ring[r % RING_ROWS][c];
                end
            end
            w.edge_res = (acc == FLAG_BOTH);
            w.last     = (results_out == frame_words() - 1);
            pending_edges.push_back(w);
            results_out++;
            if (results_out >= frame_words()) begin
                busy = 0;
                col_at = 0;
                row_at = 0;
                words_in = 0;
                results_out = 0;
            end
        endfunction

        function void take_sample_word(logic cmd, logic signed [SAMPLE_BITS-1:0] smp);
            int s, t, lag;
            logic [1:0] f;
            if (cmd == CMD_PIXEL && !busy) begin
                cols = (fw_reg == 0) ? 1 : (fw_reg > WIDTH_LIMIT) ? MAX_WIDTH : int'(fw_reg);
                rows = (fh_reg == 0) ? 1 :
                       (fh_reg > HEIGHT_LIMIT) ? int'(HEIGHT_LIMIT) : int'(fh_reg);
                half = int'(win_reg) / 2;
                col_at = 0;
                row_at = 0;
                words_in = 0;
                results_out = 0;
                busy = 1;
            end
            if (!busy) return;
            lag = half * cols + half;
            if (words_in < frame_words()) begin
                if (cmd == CMD_DRAIN) return;
                s = smp;
                t = int'(thr_reg);
                f = FLAG_NONE;
                f[0] = (s > t);
                f[1] = (s < -t);
                flag_ring[row_at % RING_ROWS][col_at] = f;
                words_in++;
                col_at++;
                if (col_at >= cols) begin
                    col_at = 0;
                    row_at++;
                end
                if (words_in - 1 >= lag) predict_window_edge();
                return;
            end
            predict_window_edge();
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        task check_edge_word(logic edge_res, logic last);
            t_edge_word w;
            if (pending_edges.size() == 0) begin
                report_mismatch("result word with nothing pending");
                return;
            end
            w = pending_edges.pop_front();
            if (edge_res !== w.edge_res)
                report_mismatch($sformatf("edge_res %b, predicted %b", edge_res, w.edge_res));
            if (last !== w.last)
                report_mismatch($sformatf("last %b, predicted %b", last, w.last));
        endtask
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [CFG_IDX_BITS-1:0]       i_cfg_idx;
    logic [CFG_DATA_BITS-1:0]      i_cfg_data;
    logic                          i_in_valid;
    logic                          o_in_stall;
    logic                          i_in_cmd;
    logic signed [SAMPLE_BITS-1:0] i_in_sample;
    logic                          o_out_valid;
    logic                          i_out_stall;
    logic                          o_out_edge_res;
    logic                          o_out_last;

    crossing_scoreboard sb = new();
    bit in_gaps_on  = 1'b1;
    bit out_gaps_on = 1'b1;
    int fed_words;
    int quiet_cycles;

    zero_crossing_window_detect_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_in_cmd       (i_in_cmd),
        .i_in_sample    (i_in_sample),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_edge_res (o_out_edge_res),
        .o_out_last     (o_out_last)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0)
            sb.check_edge_word(o_out_edge_res, o_out_last);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_stall === 1'b0) ||
            (o_out_valid === 1'b1 && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("tb_zero_crossing_window_detect_top: errors");
            $finish;
        end
    end

    initial begin : out_pacing
        int hold;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            hold = out_gaps_on ? $urandom_range(0, 19) : 0;
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
        end
    end

    task automatic send_word(input logic cmd, input logic signed [SAMPLE_BITS-1:0] smp);
        int gap;
        gap = in_gaps_on ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_in_cmd    <= cmd;
        i_in_sample <= smp;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.take_sample_word(cmd, smp);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        sb.set_reg(idx, data);
        @(negedge i_clk);
    endtask

    task automatic program_regs(input int thr, input int win, input int fw, input int fh);
        write_reg(REG_THRESHOLD,    CFG_DATA_BITS'(thr));
        write_reg(REG_WINDOW_SIZE,  CFG_DATA_BITS'(win));
        write_reg(REG_FRAME_WIDTH,  CFG_DATA_BITS'(fw));
        write_reg(REG_FRAME_HEIGHT, CFG_DATA_BITS'(fh));
        i_cfg_we <= 1'b0;
    endtask

    // hold input idle until every predicted word is out, then let the pipe empty
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending_edges.size() != 0) @(negedge i_clk);
        repeat (16) @(negedge i_clk);
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] draw_sample();
        int t, v;
        t = int'(sb.thr_reg);
        case ($urandom_range(0, 7))
            0, 1: v = int'($signed(SAMPLE_BITS'($urandom)));
            2: v = t + 1 + int'($urandom_range(0, 3));
            3: v = -t - 1 - int'($urandom_range(0, 3));
            4: v = $urandom_range(0, 1) ? t : -t;
            5: v = int'($urandom_range(0, 2 * t)) - t;
            6: v = $urandom_range(0, 1) ? 32767 : -32768;
            default: v = int'($urandom_range(0, 64)) - 32;
        endcase
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return SAMPLE_BITS'(v);
    endfunction

    task automatic run_frame();
        do begin
            if ($urandom_range(0, 15) == 0) send_word(CMD_DRAIN, SAMPLE_BITS'($urandom));
            send_word(CMD_PIXEL, draw_sample());
            fed_words++;
        end while (sb.busy && sb.words_in < sb.frame_words());
        while (sb.busy) begin
            if ($urandom_range(0, 7) == 0)
                send_word(CMD_PIXEL, SAMPLE_BITS'($urandom));
            else
                send_word(CMD_DRAIN, SAMPLE_BITS'($urandom));
            fed_words++;
        end
        if ($urandom_range(0, 3) == 0) send_word(CMD_DRAIN, SAMPLE_BITS'($urandom));
        settle();
    endtask

    initial begin
        logic signed [SAMPLE_BITS-1:0] corner [9];
        int thr, fw;
        corner = '{16'sd32767, -16'sd32768, 16'sd100, -16'sd100, 16'sd101,
                   -16'sd101, 16'sd0, -16'sd1, 16'sh4000};
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = REG_THRESHOLD;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_in_cmd    = CMD_PIXEL;
        i_in_sample = '0;
        fed_words   = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // drain with no frame open: dropped
        send_word(CMD_DRAIN, -16'sd1);
        settle();

        // samples on and around the threshold, a stray drain mid-frame,
        // a pixel past the frame end that acts as a drain
        program_regs(100, 3, 3, 3);
        foreach (corner[i]) begin
            if (i == 4) send_word(CMD_DRAIN, 16'sh7FFF);
            send_word(CMD_PIXEL, corner[i]);
        end
        send_word(CMD_PIXEL, 16'sh7FFF);
        while (sb.busy) send_word(CMD_DRAIN, SAMPLE_BITS'($urandom));
        settle();

        // zero width, height and window: single-pixel frames
        program_regs(0, 0, 0, 0);
        send_word(CMD_PIXEL, 16'sd1);
        send_word(CMD_PIXEL, -16'sd1);
        settle();

        // full window on a frame smaller than its lag
        program_regs(32767, 7, 2, 2);
        send_word(CMD_PIXEL, -16'sd32768);
        send_word(CMD_PIXEL, 16'sd32767);
        send_word(CMD_PIXEL, -16'sd32767);
        send_word(CMD_PIXEL, 16'sd0);
        while (sb.busy) send_word(CMD_DRAIN, SAMPLE_BITS'($urandom));
        settle();

        // oversize width and height saturate to the limits
        program_regs(32767, 7, 2047, 1);
        run_frame();
        in_gaps_on  = 1'b0;
        out_gaps_on = 1'b0;
        program_regs(0, 5, 1, 8191);
        run_frame();

        fed_words = 0;
        while (fed_words < RANDOM_WORDS) begin
            case ($urandom_range(0, 3))
                0: thr = 0;
                1: thr = 32767;
                2: thr = $urandom_range(0, 32767);
                default: thr = $urandom_range(0, 300);
            endcase
            fw = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(0, 16);
            in_gaps_on  = ($urandom_range(0, 3) != 0);
            out_gaps_on = ($urandom_range(0, 3) != 0);
            program_regs(thr, $urandom_range(0, 7), fw, $urandom_range(0, 12));
            run_frame();
        end

        settle();
        if (sb.pending_edges.size() != 0)
            sb.report_mismatch($sformatf("%0d predicted words never arrived",
                                         sb.pending_edges.size()));
        if (sb.errors == 0)
            $display("tb_zero_crossing_window_detect_top: clean");
        else
            $display("tb_zero_crossing_window_detect_top: errors");
        $finish;
    end

endmodule
